FILE: rtl/assert_macros.svh
// Assertion macros for the train PWM ramp sequencer RTL.
// Depends on nothing; files that assert include it and supply clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset
`define TPRS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Implication checked on every clock edge outside reset
`define TPRS_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define TPRS_ASSERT(name, prop, msg)
`define TPRS_ASSERT_IMPL(name, ante, cons, msg)
`endif
`endif

FILE: rtl/tprs_pkg.sv
// Shared types, constants and helper functions of the train PWM ramp sequencer.
// No dependencies; imported by every RTL module of the block.
package tprs_pkg;

   // Widths
   localparam int DUTY_BITS = 10;
   localparam int REG_DUTY_W = 10;
   localparam int WAIT_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CMP_W = 17;

   localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

   // Fixed mountain timeouts in ticks
   localparam logic [WAIT_W-1:0] LEFT_MOUNTAIN_DELAY = 16'd1000;
   localparam logic [WAIT_W-1:0] RIGHT_MOUNTAIN_DELAY = 16'd1000;

   // Routine commands
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_LEFT  = 2'd1,
      CMD_RIGHT = 2'd2,
      CMD_BRAKE = 2'd3
   } cmd_type;

   // Reed contact codes; other codes mean no contact
   localparam logic [2:0] REED_NONE = 3'd0;
   localparam logic [2:0] REED_LU = 3'd1;
   localparam logic [2:0] REED_LD = 3'd2;
   localparam logic [2:0] REED_RU = 3'd3;
   localparam logic [2:0] REED_RD = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHTS_WAIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAIN_WAIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STANDSTILL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_INT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_INT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DESCENT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIMB = 3'd7;

   typedef struct packed {
      logic [WAIT_W-1:0]     lights_wait_ticks;
      logic [WAIT_W-1:0]     train_wait_ticks;
      logic [REG_DUTY_W-1:0] standstill_duty;
      logic [REG_DUTY_W-1:0] cruise_duty;
      logic [WAIT_W-1:0]     ramp_interval;
      logic [WAIT_W-1:0]     brake_ramp_interval;
      logic [REG_DUTY_W-1:0] descent_duty;
      logic [REG_DUTY_W-1:0] climb_duty;
   } cfg_type;

   typedef struct packed {
      logic                 finished;
      logic                 duty_write;
      logic [DUTY_BITS-1:0] duty_value;
      logic                 brake_on;
   } result_type;

   // Clamp a register duty value to the duty range
   function automatic logic [DUTY_BITS-1:0] sat_duty(input logic [REG_DUTY_W-1:0] v);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(v);
      if (wide > CMP_W'(DUTY_MAX)) return DUTY_MAX;
      return wide[DUTY_BITS-1:0];
   endfunction

   // Widen a duty for compares against register values
   function automatic logic [CMP_W-1:0] duty_ext(input logic [DUTY_BITS-1:0] v);
      return CMP_W'(v);
   endfunction

   function automatic logic [CMP_W-1:0] reg_ext(input logic [REG_DUTY_W-1:0] v);
      return CMP_W'(v);
   endfunction

endpackage

FILE: rtl/tprs_if.sv
// Valid/ready channel interfaces for tick commands and sequencer results.
// Depends on tprs_pkg for payload widths.
interface tprs_req_if import tprs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [2:0] reed;

   modport source (output valid, output cmd, output reed, input ready);
   modport sink (input valid, input cmd, input reed, output ready);
endinterface

interface tprs_rsp_if import tprs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 finished;
   logic                 duty_write;
   logic [DUTY_BITS-1:0] duty_value;
   logic                 brake_on;

   modport source (output valid, output finished, output duty_write, output duty_value,
                   output brake_on, input ready);
   modport sink (input valid, input finished, input duty_write, input duty_value,
                 input brake_on, output ready);
endinterface

FILE: rtl/tprs_csr.sv
// Configuration register file of the train PWM ramp sequencer.
// Depends on tprs_pkg for the register indexes and the cfg_type struct.
module tprs_csr import tprs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LIGHTS_WAIT: cfg_in.lights_wait_ticks = csr_wdata;
            CSR_TRAIN_WAIT:  cfg_in.train_wait_ticks = csr_wdata;
            CSR_STANDSTILL:  cfg_in.standstill_duty = csr_wdata[REG_DUTY_W-1:0];
            CSR_CRUISE:      cfg_in.cruise_duty = csr_wdata[REG_DUTY_W-1:0];
            CSR_RAMP_INT:    cfg_in.ramp_interval = csr_wdata;
            CSR_BRAKE_INT:   cfg_in.brake_ramp_interval = csr_wdata;
            CSR_DESCENT:     cfg_in.descent_duty = csr_wdata[REG_DUTY_W-1:0];
            CSR_CLIMB:       cfg_in.climb_duty = csr_wdata[REG_DUTY_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/tprs_seq.sv
// Routine sequencer: phase, duty, counter and brake state plus one tick of work.
// Depends on tprs_pkg for cfg_type, result_type, codes and duty helpers.
module tprs_seq import tprs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       tick,
   input  logic [1:0] cmd,
   input  logic [2:0] reed,
   input  cfg_type    cfg,
   output result_type result
);

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2,
      PH_FOURTH = 2'd3
   } phase_type;

   phase_type            move_phase_ff, move_phase_in;
   logic                 mountain_phase_ff, mountain_phase_in;
   logic [DUTY_BITS-1:0] duty_ff, duty_in;
   logic [WAIT_W-1:0]    step_count_ff, step_count_in;
   logic [WAIT_W-1:0]    start_wait_ff, start_wait_in;
   logic [WAIT_W-1:0]    stop_wait_ff, stop_wait_in;
   logic [WAIT_W-1:0]    mountain_wait_ff, mountain_wait_in;
   logic                 brake_flag_ff, brake_flag_in;

   logic                 fin;
   logic                 wr;
   logic [DUTY_BITS-1:0] wr_val;

   logic [DUTY_BITS-1:0] duty_up;
   logic [DUTY_BITS-1:0] duty_down;
   logic [DUTY_BITS-1:0] standstill_sat;
   logic [WAIT_W-1:0]    step_next;
   logic                 ramp_due;

   // Per-mountain contact set and slew targets
   logic                  is_left;
   logic [2:0]            arrive_code;
   logic [WAIT_W-1:0]     mountain_delay;
   logic [2:0]            contact_a;
   logic [2:0]            contact_b;
   logic                  hit_a;
   logic                  hit_b;
   logic                  slew_rising;
   logic [REG_DUTY_W-1:0] slew_limit;
   logic                  slew_done;

   // Saturating duty steps and common counter values
   assign duty_up = (duty_ff == DUTY_MAX) ? duty_ff : duty_ff + 1'b1;
   assign duty_down = (duty_ff == '0) ? duty_ff : duty_ff - 1'b1;
   assign standstill_sat = sat_duty(cfg.standstill_duty);
   assign step_next = step_count_ff + 1'b1;
   assign ramp_due = step_count_ff >= cfg.ramp_interval;

   // Select the contacts and limits of the addressed mountain
   assign is_left = (cmd_type'(cmd) == CMD_LEFT);
   assign arrive_code = is_left ? REED_LD : REED_RU;
   assign mountain_delay = is_left ? LEFT_MOUNTAIN_DELAY : RIGHT_MOUNTAIN_DELAY;
   assign contact_a = is_left ? REED_LU : REED_RD;
   assign contact_b = is_left ? REED_LD : REED_RU;
   assign hit_a = (reed == contact_a);
   assign hit_b = (reed == contact_b);
   // Left: descend falling to descent duty, leave rising to cruise.
   // Right: climb rising to climb duty, leave falling to cruise.
   assign slew_rising = hit_a ? !is_left : is_left;
   assign slew_limit = hit_a ? (is_left ? cfg.descent_duty : cfg.climb_duty) : cfg.cruise_duty;
   assign slew_done = slew_rising ? (duty_ext(duty_ff) >= reg_ext(slew_limit))
                                  : (duty_ext(duty_ff) <= reg_ext(slew_limit));

   // Advance the addressed routine by one tick
   always_comb begin
      move_phase_in = move_phase_ff;
      mountain_phase_in = mountain_phase_ff;
      duty_in = duty_ff;
      step_count_in = step_count_ff;
      start_wait_in = start_wait_ff;
      stop_wait_in = stop_wait_ff;
      mountain_wait_in = mountain_wait_ff;
      brake_flag_in = brake_flag_ff;
      fin = 1'b0;
      wr = 1'b0;
      wr_val = '0;

      unique case (cmd_type'(cmd))
         CMD_START: begin
            unique case (move_phase_ff)
               PH_FIRST: begin
                  if (start_wait_ff >= cfg.lights_wait_ticks) begin
                     move_phase_in = PH_SECOND;
                     start_wait_in = '0;
                  end else begin
                     start_wait_in = start_wait_ff + 1'b1;
                  end
               end
               PH_SECOND: begin
                  wr = 1'b1;
                  wr_val = standstill_sat;
                  duty_in = standstill_sat;
                  brake_flag_in = 1'b0;
                  move_phase_in = PH_THIRD;
               end
               PH_THIRD: begin
                  if (start_wait_ff >= cfg.train_wait_ticks) begin
                     move_phase_in = PH_FOURTH;
                     start_wait_in = '0;
                  end else begin
                     start_wait_in = start_wait_ff + 1'b1;
                  end
               end
               PH_FOURTH: begin
                  wr = 1'b1;
                  wr_val = duty_ff;
                  if (duty_ext(duty_ff) >= reg_ext(cfg.cruise_duty)) begin
                     move_phase_in = PH_FIRST;
                     fin = 1'b1;
                  end else if (ramp_due) begin
                     // step restarts at zero, then counts this tick
                     duty_in = duty_up;
                     step_count_in = WAIT_W'(1);
                  end else begin
                     step_count_in = step_next;
                  end
               end
               default: ;
            endcase
         end
         CMD_LEFT, CMD_RIGHT: begin
            if (!mountain_phase_ff) begin
               if (reed == arrive_code || mountain_wait_ff >= mountain_delay) begin
                  mountain_phase_in = 1'b1;
                  mountain_wait_in = '0;
               end else begin
                  mountain_wait_in = mountain_wait_ff + 1'b1;
               end
            end else if (hit_a || hit_b) begin
               wr = 1'b1;
               wr_val = duty_ff;
               if (slew_done) begin
                  move_phase_in = PH_FIRST;
                  mountain_phase_in = 1'b0;
                  fin = 1'b1;
               end else if (ramp_due) begin
                  duty_in = slew_rising ? duty_up : duty_down;
                  step_count_in = '0;
               end else begin
                  step_count_in = step_next;
               end
            end
         end
         CMD_BRAKE: begin
            unique case (move_phase_ff)
               PH_FIRST: begin
                  wr = 1'b1;
                  wr_val = duty_ff;
                  if (duty_ext(duty_ff) <= reg_ext(cfg.standstill_duty)) begin
                     move_phase_in = PH_SECOND;
                  end else if (step_count_ff >= cfg.brake_ramp_interval) begin
                     duty_in = duty_down;
                     step_count_in = '0;
                  end else begin
                     step_count_in = step_next;
                  end
               end
               PH_SECOND: begin
                  if (stop_wait_ff >= cfg.train_wait_ticks) begin
                     move_phase_in = PH_THIRD;
                     stop_wait_in = '0;
                  end else begin
                     stop_wait_in = stop_wait_ff + 1'b1;
                  end
               end
               PH_THIRD: begin
                  wr = 1'b1;
                  wr_val = standstill_sat;
                  brake_flag_in = 1'b1;
                  duty_in = standstill_sat;
                  move_phase_in = PH_FOURTH;
               end
               PH_FOURTH: begin
                  if (stop_wait_ff >= cfg.lights_wait_ticks) begin
                     move_phase_in = PH_FIRST;
                     stop_wait_in = '0;
                     fin = 1'b1;
                  end else begin
                     stop_wait_in = stop_wait_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Hold state between ticks; update once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         move_phase_ff <= PH_FIRST;
         mountain_phase_ff <= 1'b0;
         duty_ff <= '0;
         step_count_ff <= '0;
         start_wait_ff <= '0;
         stop_wait_ff <= '0;
         mountain_wait_ff <= '0;
         brake_flag_ff <= 1'b0;
      end else if (tick) begin
         move_phase_ff <= move_phase_in;
         mountain_phase_ff <= mountain_phase_in;
         duty_ff <= duty_in;
         step_count_ff <= step_count_in;
         start_wait_ff <= start_wait_in;
         stop_wait_ff <= stop_wait_in;
         mountain_wait_ff <= mountain_wait_in;
         brake_flag_ff <= brake_flag_in;
      end
   end

   assign result.finished = fin;
   assign result.duty_write = wr;
   assign result.duty_value = wr_val;
   assign result.brake_on = brake_flag_in;

endmodule

FILE: rtl/train_pwm_ramp_sequencer.sv
// Top level of the train PWM ramp sequencer: handshake stages around the sequencer.
// Depends on tprs_pkg, tprs_if, tprs_csr, tprs_seq and assert_macros.svh.
//
//   channel | dir | handshake        | payload
//   req     | in  | valid/ready      | cmd, reed
//   rsp     | out | valid/ready      | finished, duty_write, duty_value, brake_on
//   csr     | in  | write enable     | csr_index, csr_wdata
//
// One transaction per cycle while rsp.ready stays high; a result is offered on rsp
// once its request has passed the input register, then the one-tick routine logic
// into the result register. Reset is synchronous and clears phases, counters, duty,
// brake and registers. A stalled result holds in the result register while the input
// register still takes one more transaction; req.ready drops only when both are full.
`include "assert_macros.svh"
module train_pwm_ramp_sequencer import tprs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tprs_req_if.sink              req,
   tprs_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   result_type step_result;

   logic       stage_valid_ff;
   logic [1:0] stage_cmd_ff;
   logic [2:0] stage_reed_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   logic       advance;
   logic       req_fire;
   logic       stage_stall;
   logic       rsp_value_ok;

   tprs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tprs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .tick   (advance),
      .cmd    (stage_cmd_ff),
      .reed   (stage_reed_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   // Move the staged transaction on when the result register is free or draining
   assign advance = stage_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !stage_valid_ff || advance;
   assign req_fire = req.valid && req.ready;
   assign stage_stall = stage_valid_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req.ready) begin
         stage_valid_ff <= req.valid;
      end
      if (req_fire) begin
         stage_cmd_ff <= req.cmd;
         stage_reed_ff <= req.reed;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.finished = rsp_data_ff.finished;
   assign rsp.duty_write = rsp_data_ff.duty_write;
   assign rsp.duty_value = rsp_data_ff.duty_value;
   assign rsp.brake_on = rsp_data_ff.brake_on;

   // A duty value only travels with a write
   assign rsp_value_ok = rsp_data_ff.duty_write || (rsp_data_ff.duty_value == '0);

   `TPRS_ASSERT_IMPL(a_accept_staged, req_fire, ##1 stage_valid_ff, "transaction not staged")
   `TPRS_ASSERT_IMPL(a_hold, stage_stall, ##1 stage_valid_ff && $stable(stage_cmd_ff), "stage lost")
   `TPRS_ASSERT_IMPL(a_advance_fills, advance, ##1 rsp_valid_ff, "advance produced no result")
   `TPRS_ASSERT_IMPL(a_no_write_zero, rsp_valid_ff, rsp_value_ok, "duty value set without a write")

endmodule
